// ===== hdl/imh_pkg.sv =====
`timescale 1ns / 1ps
package imh_pkg;

  localparam int VAL_W  = 10;
  localparam int VIDS   = 1024;
  localparam int CNT_W  = 11;
  localparam int STAT_W = 3;

  typedef enum logic [1:0] {
    CMD_INSERT   = 2'd0,
    CMD_EXTRACT  = 2'd1,
    CMD_DECREASE = 2'd2,
    CMD_NOP      = 2'd3
  } cmd_t;

  localparam logic [STAT_W-1:0] ST_OK     = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL   = 3'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY  = 3'd2;
  localparam logic [STAT_W-1:0] ST_LARGER = 3'd3;
  localparam logic [STAT_W-1:0] ST_ABSENT = 3'd4;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_INS_WRITE,
    S_EXT_RD_LAST,
    S_EXT_WAIT_LAST,
    S_EXT_WRITE_ROOT,
    S_DEC_RD_MAP,
    S_DEC_WAIT_MAP,
    S_DEC_RD_POS,
    S_DEC_WAIT_POS,
    S_DEC_CHECK,
    S_UP_RD,
    S_UP_WAIT,
    S_UP_CMP,
    S_DN_RD_L,
    S_DN_RD_R,
    S_DN_WAIT,
    S_DN_CMP,
    S_SWAP_A,
    S_SWAP_B,
    S_ROOT_RD,
    S_ROOT_WAIT,
    S_DONE,
    S_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic       clear_step;
    logic       capture_in;
    logic       ins_begin;      // count++, cur = count, write new entry
    logic       ext_begin;      // latch root as extracted, clear its map entry
    logic       rd_last;        // read heap[count]
    logic       wr_root_last;   // write last entry to root, count--, cur = 1
    logic       ext_to_empty;   // count = 0
    logic       rd_map;
    logic       rd_pos;         // read heap[map result]
    logic       dec_write;      // write new key at cur
    logic       rd_parent;
    logic       rd_left;
    logic       rd_right;
    logic       cap_left;
    logic       cap_right;
    logic       cap_cur;        // set on insert write; the datapath does not read it
    logic       swap_a;         // write partner data at cur
    logic       swap_b;         // write cur data at partner, cur = partner
    logic       rd_root;
    logic       cap_root;
    logic [STAT_W-1:0] set_status;
    logic       status_we;
    logic       out_load;
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic clear_done;
    logic full;
    logic empty;
    logic one_left;
    logic cur_is_root;
    logic parent_less;   // heap[cur] < heap[parent]
    logic has_left;
    logic has_right;
    logic down_swap;     // a child is smaller
    logic dec_absent;
    logic dec_larger;
  } sts_t;

endpackage

// ===== hdl/indexed_min_heap.sv =====
`timescale 1ns / 1ps
// Indexed binary min-heap with decrease-key, one command item at a time.
// Insert writes the new entry at the end and climbs; decrease reads the map
// and the target entry, checks it and climbs; extract moves the last entry to
// the root and descends; every item then reads the root for its result.
// New items wait until the previous result is loaded; serial heap walk.
// Reset: synchronous, active low; a clearing pass then zeroes the position
// map, and no item is accepted until it finishes.
module indexed_min_heap
  import imh_pkg::*;
#(
  parameter int DEPTH     = 1024,
  parameter int KEY_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_write,
  input  logic [CNT_W-1:0]            cfg_capacity,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_command,
  input  logic signed [KEY_WIDTH-1:0] in_new_key,
  input  logic [VAL_W-1:0]            in_item_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [STAT_W-1:0]           out_status,
  output logic signed [KEY_WIDTH-1:0] out_key,
  output logic [VAL_W-1:0]            out_value,
  output logic                        out_min_valid,
  output logic signed [KEY_WIDTH-1:0] out_min_key,
  output logic [VAL_W-1:0]            out_min_value,
  output logic [CNT_W-1:0]            out_entry_count
);
  ctl_t ctl;
  sts_t sts;
  cmd_t cmd;

  // Sequencer: steps each command through reads, compares and swap writes.
  imh_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_stall(out_stall), .out_valid(out_valid), .cmd(cmd), .sts(sts), .ctl(ctl)
  );

  // Datapath: heap and map memories, count, capacity, result register.
  imh_datapath #(.DEPTH(DEPTH), .KEY_WIDTH(KEY_WIDTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .sts(sts),
    .cfg_write(cfg_write), .cfg_data(cfg_capacity),
    .in_command(in_command), .in_new_key(in_new_key), .in_item_value(in_item_value),
    .cmd(cmd), .out_status(out_status), .out_key(out_key), .out_value(out_value),
    .out_min_valid(out_min_valid), .out_min_key(out_min_key),
    .out_min_value(out_min_value), .out_entry_count(out_entry_count)
  );
endmodule

// ===== hdl/imh_ram.sv =====
`timescale 1ns / 1ps
module imh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hdl/imh_ctrl.sv =====
`timescale 1ns / 1ps
module imh_ctrl
  import imh_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_stall,
  input  logic   out_stall,
  output logic   out_valid,
  input  cmd_t   cmd,
  input  sts_t   sts,
  output ctl_t   ctl
);
  state_t state_r, state_nxt;
  logic   dec_mode_r, dec_mode_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      dec_mode_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dec_mode_r  <= dec_mode_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign in_stall  = (state_r != S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    dec_mode_nxt = dec_mode_r;
    case (state_r)
      S_CLEAR:   if (sts.clear_done) state_nxt = S_IDLE;
      S_IDLE:    if (in_valid) state_nxt = S_DISPATCH;
      S_DISPATCH: begin
        case (cmd)
          CMD_INSERT:   state_nxt = sts.full ? S_ROOT_RD : S_INS_WRITE;
          CMD_EXTRACT: begin
            if (sts.empty) state_nxt = S_ROOT_RD;
            else if (sts.one_left) state_nxt = S_ROOT_RD;
            else state_nxt = S_EXT_RD_LAST;
          end
          CMD_DECREASE: state_nxt = S_DEC_RD_MAP;
          default:      state_nxt = S_ROOT_RD;
        endcase
      end
      S_INS_WRITE:      state_nxt = S_UP_RD;
      S_EXT_RD_LAST:    state_nxt = S_EXT_WAIT_LAST;
      S_EXT_WAIT_LAST:  state_nxt = S_EXT_WRITE_ROOT;
      S_EXT_WRITE_ROOT: begin
        dec_mode_nxt = 1'b1;
        state_nxt    = S_DN_RD_L;
      end
      S_DEC_RD_MAP:   state_nxt = S_DEC_WAIT_MAP;
      S_DEC_WAIT_MAP: state_nxt = S_DEC_RD_POS;
      S_DEC_RD_POS:   state_nxt = S_DEC_WAIT_POS;
      S_DEC_WAIT_POS: state_nxt = S_DEC_CHECK;
      S_DEC_CHECK: begin
        if (sts.dec_absent || sts.dec_larger) state_nxt = S_ROOT_RD;
        else state_nxt = S_UP_RD;
      end
      S_UP_RD: begin
        dec_mode_nxt = 1'b0;
        state_nxt = sts.cur_is_root ? S_ROOT_RD : S_UP_WAIT;
      end
      S_UP_WAIT: state_nxt = S_UP_CMP;
      S_UP_CMP:  state_nxt = sts.parent_less ? S_SWAP_A : S_ROOT_RD;
      S_DN_RD_L: state_nxt = sts.has_left ? S_DN_RD_R : S_ROOT_RD;
      S_DN_RD_R: state_nxt = S_DN_WAIT;
      S_DN_WAIT: state_nxt = S_DN_CMP;
      S_DN_CMP:  state_nxt = sts.down_swap ? S_SWAP_A : S_ROOT_RD;
      S_SWAP_A:  state_nxt = S_SWAP_B;
      S_SWAP_B:  state_nxt = dec_mode_r ? S_DN_RD_L : S_UP_RD;
      S_ROOT_RD:   state_nxt = S_ROOT_WAIT;
      S_ROOT_WAIT: state_nxt = S_DONE;
      S_DONE:      state_nxt = S_OUT;
      S_OUT:       if (!out_valid_r || !out_stall) state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_CLEAR: ctl.clear_step = 1'b1;
      S_IDLE:  ctl.capture_in = in_valid;
      S_DISPATCH: begin
        ctl.status_we  = 1'b1;
        ctl.set_status = ST_OK;
        case (cmd)
          CMD_INSERT: begin
            if (sts.full) ctl.set_status = ST_FULL;
            else ctl.ins_begin = 1'b1;
          end
          CMD_EXTRACT: begin
            if (sts.empty) ctl.set_status = ST_EMPTY;
            else begin
              ctl.ext_begin = 1'b1;
              ctl.ext_to_empty = sts.one_left;
            end
          end
          default: ;
        endcase
      end
      S_INS_WRITE:      ctl.cap_cur = 1'b1;
      S_EXT_RD_LAST:    ctl.rd_last = 1'b1;
      S_EXT_WRITE_ROOT: ctl.wr_root_last = 1'b1;
      S_DEC_RD_MAP:     ctl.rd_map = 1'b1;
      S_DEC_RD_POS:     ctl.rd_pos = 1'b1;
      S_DEC_CHECK: begin
        if (sts.dec_absent) begin
          ctl.status_we = 1'b1; ctl.set_status = ST_ABSENT;
        end else if (sts.dec_larger) begin
          ctl.status_we = 1'b1; ctl.set_status = ST_LARGER;
        end else begin
          ctl.dec_write = 1'b1;
        end
      end
      S_UP_RD:   ctl.rd_parent = 1'b1;
      S_UP_WAIT: ctl.cap_left = 1'b1;
      S_DN_RD_L: ctl.rd_left = 1'b1;
      S_DN_RD_R: begin
        ctl.rd_right = 1'b1;
        ctl.cap_left = 1'b1;
      end
      S_DN_WAIT: ctl.cap_right = 1'b1;
      S_DN_CMP:  ;
      S_SWAP_A:  ctl.swap_a = 1'b1;
      S_SWAP_B:  ctl.swap_b = 1'b1;
      S_ROOT_RD: ctl.rd_root = 1'b1;
      S_ROOT_WAIT: ctl.cap_root = 1'b1;
      S_DONE:    ;
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          ctl.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end
endmodule

// ===== hdl/imh_datapath.sv =====
`timescale 1ns / 1ps
module imh_datapath
  import imh_pkg::*;
#(
  parameter int DEPTH     = 1024,
  parameter int KEY_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ctl_t                        ctl,
  output sts_t                        sts,
  input  logic                        cfg_write,
  input  logic [CNT_W-1:0]            cfg_data,
  input  logic [1:0]                  in_command,
  input  logic signed [KEY_WIDTH-1:0] in_new_key,
  input  logic [VAL_W-1:0]            in_item_value,
  output cmd_t                        cmd,
  output logic [STAT_W-1:0]           out_status,
  output logic signed [KEY_WIDTH-1:0] out_key,
  output logic [VAL_W-1:0]            out_value,
  output logic                        out_min_valid,
  output logic signed [KEY_WIDTH-1:0] out_min_key,
  output logic [VAL_W-1:0]            out_min_value,
  output logic [CNT_W-1:0]            out_entry_count
);
  // Positions run 1..DEPTH; heap RAM has DEPTH+1 rows.
  localparam int PW    = $clog2(DEPTH + 1);
  localparam int HROWS = DEPTH + 1;
  localparam int HAW   = $clog2(HROWS);
  localparam int EW    = KEY_WIDTH + VAL_W;
  localparam int MAW   = $clog2(VIDS);
  localparam int LIMW  = (PW > CNT_W) ? PW : CNT_W;

  logic [CNT_W-1:0] cap_r;
  logic [PW-1:0]    count_r, cur_r, part_r;
  logic [MAW:0]     clr_r;
  cmd_t             cmd_r;
  logic signed [KEY_WIDTH-1:0] key_r;
  logic [VAL_W-1:0] val_r;
  logic [KEY_WIDTH-1:0] ck_r, lk_r, rk_r;
  logic [VAL_W-1:0] cv_r, lv_r, rv_r;
  logic [PW-1:0]    dpos_r;
  logic [STAT_W-1:0] stat_r;
  logic [KEY_WIDTH-1:0] xk_r;
  logic [VAL_W-1:0] xv_r;
  logic [KEY_WIDTH-1:0] rootk_r;
  logic [VAL_W-1:0] rootv_r;

  // heap RAM
  logic           h_we;
  logic [HAW-1:0] h_wa, h_ra;
  logic [EW-1:0]  h_wd, h_rd;
  // map RAM
  logic           m_we;
  logic [MAW-1:0] m_wa, m_ra;
  logic [PW-1:0]  m_wd, m_rd;

  imh_ram #(.WIDTH(EW), .DEPTH(HROWS)) u_heap (
    .clk(clk), .we(h_we), .waddr(h_wa), .wdata(h_wd), .raddr(h_ra), .rdata(h_rd)
  );
  imh_ram #(.WIDTH(PW), .DEPTH(VIDS)) u_map (
    .clk(clk), .we(m_we), .waddr(m_wa), .wdata(m_wd), .raddr(m_ra), .rdata(m_rd)
  );

  logic [KEY_WIDTH-1:0] rd_k;
  logic [VAL_W-1:0]     rd_v;
  assign rd_k = h_rd[EW-1:VAL_W];
  assign rd_v = h_rd[VAL_W-1:0];

  logic [PW:0] lpos, rpos;
  assign lpos = {cur_r, 1'b0};
  assign rpos = {cur_r, 1'b1};

  logic [LIMW-1:0] lim;
  assign lim = (LIMW'(cap_r) < LIMW'(DEPTH)) ? LIMW'(cap_r) : LIMW'(DEPTH);

  // down-step choice (children latched in lk/rk; cur in ck)
  logic has_l, has_r, l_lt, r_lt_best, pick_r;
  assign has_l = ({1'b0, count_r} >= lpos);
  assign has_r = ({1'b0, count_r} >= rpos);
  assign l_lt  = has_l && ($signed(lk_r) < $signed(ck_r));
  assign r_lt_best = has_r && (l_lt ? ($signed(rk_r) < $signed(lk_r))
                                    : ($signed(rk_r) < $signed(ck_r)));
  assign pick_r = r_lt_best;

  always_comb begin
    sts.clear_done  = clr_r[MAW];
    sts.full        = (LIMW'(count_r) >= lim);
    sts.empty       = (count_r == '0);
    sts.one_left    = (count_r == PW'(1));
    sts.cur_is_root = (cur_r <= PW'(1));
    sts.parent_less = ($signed(ck_r) < $signed(lk_r));
    sts.has_left    = has_l;
    sts.has_right   = has_r;
    sts.down_swap   = l_lt || r_lt_best;
    sts.dec_absent  = (dpos_r == '0) || (dpos_r > count_r) || (cv_r != val_r);
    sts.dec_larger  = ($signed(ck_r) < key_r);
  end

  assign cmd = cmd_r;

  // RAM port steering
  always_comb begin
    h_we = 1'b0; h_wa = '0; h_wd = '0; h_ra = '0;
    m_we = 1'b0; m_wa = '0; m_wd = '0; m_ra = val_r[MAW-1:0];
    if (ctl.clear_step) begin
      m_we = !clr_r[MAW]; m_wa = clr_r[MAW-1:0]; m_wd = '0;
    end
    if (ctl.ins_begin) begin
      h_we = 1'b1; h_wa = HAW'(count_r + PW'(1)); h_wd = {key_r, val_r};
      m_we = 1'b1; m_wa = val_r[MAW-1:0]; m_wd = count_r + PW'(1);
    end
    if (ctl.ext_begin) begin
      m_we = 1'b1; m_wa = rootv_r[MAW-1:0]; m_wd = '0;
    end
    if (ctl.rd_last) h_ra = HAW'(count_r);
    if (ctl.wr_root_last) begin
      h_we = 1'b1; h_wa = HAW'(1); h_wd = {lk_r, lv_r};
      m_we = 1'b1; m_wa = lv_r[MAW-1:0]; m_wd = PW'(1);
    end
    if (ctl.rd_pos) h_ra = HAW'(m_rd);
    if (ctl.dec_write) begin
      h_we = 1'b1; h_wa = HAW'(cur_r); h_wd = {key_r, cv_r};
    end
    if (ctl.rd_parent) h_ra = HAW'(cur_r >> 1);
    if (ctl.rd_left)   h_ra = HAW'(lpos);
    if (ctl.rd_right)  h_ra = HAW'(rpos);
    if (ctl.swap_a) begin
      h_we = 1'b1; h_wa = HAW'(cur_r);
      h_wd = {lk_r, lv_r};
      m_we = 1'b1; m_wa = lv_r[MAW-1:0]; m_wd = cur_r;
    end
    if (ctl.swap_b) begin
      h_we = 1'b1; h_wa = HAW'(part_r); h_wd = {ck_r, cv_r};
      m_we = 1'b1; m_wa = cv_r[MAW-1:0]; m_wd = part_r;
    end
    if (ctl.rd_root) h_ra = HAW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r   <= '0;
      count_r <= '0;
      cap_r   <= CNT_W'(VIDS);
      out_status <= '0; out_key <= '0; out_value <= '0;
      out_min_valid <= 1'b0; out_min_key <= '0; out_min_value <= '0;
      out_entry_count <= '0;
    end else begin
      if (cfg_write) cap_r <= cfg_data;
      if (ctl.clear_step && !clr_r[MAW]) clr_r <= clr_r + 1'b1;
      if (ctl.ins_begin) count_r <= count_r + PW'(1);
      if (ctl.ext_to_empty) count_r <= '0;
      if (ctl.wr_root_last) count_r <= count_r - PW'(1);
      if (ctl.out_load) begin
        out_status      <= stat_r;
        out_key         <= xk_r;
        out_value       <= xv_r;
        out_min_valid   <= (count_r != '0);
        out_min_key     <= (count_r != '0) ? rootk_r : '0;
        out_min_value   <= (count_r != '0) ? rootv_r : '0;
        out_entry_count <= CNT_W'(count_r);
      end
    end
  end

  // extra captures driven by state-specific commands
  logic last_cap_r, pos_cap_r, dn_sel_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_cap_r <= 1'b0; pos_cap_r <= 1'b0; dn_sel_r <= 1'b0;
    end else begin
      last_cap_r <= ctl.rd_last;
      pos_cap_r  <= ctl.rd_pos;
      dn_sel_r   <= ctl.cap_right;
    end
  end

  // payload registers; the current entry travels in ck/cv, its partner in lk/lv
  always_ff @(posedge clk) begin
    if (ctl.capture_in) begin
      cmd_r <= cmd_t'(in_command);
      key_r <= in_new_key;
      val_r <= in_item_value;
      xk_r  <= '0;
      xv_r  <= '0;
    end
    if (ctl.status_we) stat_r <= ctl.set_status;
    if (ctl.ins_begin) begin
      cur_r <= count_r + PW'(1);
      ck_r  <= key_r;
      cv_r  <= val_r;
    end
    if (ctl.ext_begin) begin
      xk_r <= rootk_r;
      xv_r <= rootv_r;
    end
    if (ctl.cap_left) begin
      lk_r <= rd_k; lv_r <= rd_v;
    end
    if (ctl.wr_root_last) begin
      cur_r <= PW'(1);
      ck_r  <= lk_r; cv_r <= lv_r;
    end
    if (ctl.rd_pos) dpos_r <= m_rd;
    if (ctl.cap_right) begin
      rk_r <= rd_k; rv_r <= rd_v;
    end
    if (ctl.dec_write) ck_r <= key_r;
    if (ctl.rd_parent) part_r <= cur_r >> 1;
    if (ctl.swap_b) cur_r <= part_r;
    if (ctl.cap_root) begin
      rootk_r <= rd_k; rootv_r <= rd_v;
    end
    // last entry and decrease target arrive in the cycle after their reads
    if (last_cap_r) begin
      lk_r <= rd_k; lv_r <= rd_v;
    end
    if (pos_cap_r) begin
      ck_r <= rd_k; cv_r <= rd_v; cur_r <= dpos_r;
    end
    if (dn_sel_r) begin
      // partner for down step: the smaller child
      if (pick_r) begin
        lk_r <= rk_r; lv_r <= rv_r; part_r <= rpos[PW-1:0];
      end else begin
        part_r <= lpos[PW-1:0];
      end
    end
  end
endmodule

// ===== verif/indexed_min_heap_checker.sv =====
`timescale 1ns / 1ps
module indexed_min_heap_checker
  import imh_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_write,
  input  logic [CNT_W-1:0]       cfg_capacity,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  logic [1:0]             in_command,
  input  logic signed [31:0]     in_new_key,
  input  logic [VAL_W-1:0]       in_item_value,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  logic [STAT_W-1:0]      out_status,
  input  logic signed [31:0]     out_key,
  input  logic [VAL_W-1:0]       out_value,
  input  logic                   out_min_valid,
  input  logic signed [31:0]     out_min_key,
  input  logic [VAL_W-1:0]       out_min_value,
  input  logic [CNT_W-1:0]       out_entry_count,
  output int                     fail_count,
  output int                     pending,
  output int                     results_seen
);

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic signed [31:0] key;
    logic [VAL_W-1:0] value;
    logic min_valid;
    logic signed [31:0] min_key;
    logic [VAL_W-1:0] min_value;
    logic [CNT_W-1:0] entry_count;
  } heap_result_t;

  localparam int SLOTS = 1024;

  logic signed [31:0] heap_key [0:SLOTS];
  logic [VAL_W-1:0]   heap_val [0:SLOTS];
  int                 where_is [0:VIDS-1];
  int                 fill;
  int                 cap_limit;
  heap_result_t       expected_q [$];

  // Place an entry and track its position
  function automatic void put(int p, logic signed [31:0] k, logic [VAL_W-1:0] v);
    heap_key[p] = k;
    heap_val[p] = v;
    where_is[v] = p;
  endfunction

  function automatic void swap_slots(int a, int b);
    logic signed [31:0] ka;
    logic [VAL_W-1:0] va;
    ka = heap_key[a];
    va = heap_val[a];
    put(a, heap_key[b], heap_val[b]);
    put(b, ka, va);
  endfunction

  function automatic void climb(int p);
    while (p > 1 && heap_key[p] < heap_key[p/2]) begin
      swap_slots(p, p/2);
      p = p/2;
    end
  endfunction

  function automatic void descend(int p);
    int l, best;
    forever begin
      l = 2*p;
      best = p;
      if (l <= fill && heap_key[l] < heap_key[best]) best = l;
      if (l+1 <= fill && heap_key[l+1] < heap_key[best]) best = l+1;
      if (best == p) return;
      swap_slots(p, best);
      p = best;
    end
  endfunction

  function automatic heap_result_t apply_command(logic [1:0] c, logic signed [31:0] k,
                                                 logic [VAL_W-1:0] v);
    heap_result_t r;
    int lim, pos;
    r = '0;
    r.status = ST_OK;
    lim = cap_limit < SLOTS ? cap_limit : SLOTS;
    case (cmd_t'(c))
      CMD_INSERT: begin
        if (fill >= lim) r.status = ST_FULL;
        else begin
          fill++;
          put(fill, k, v);
          climb(fill);
        end
      end
      CMD_EXTRACT: begin
        if (fill == 0) r.status = ST_EMPTY;
        else begin
          r.key = heap_key[1];
          r.value = heap_val[1];
          where_is[heap_val[1]] = 0;
          if (fill > 1) begin
            put(1, heap_key[fill], heap_val[fill]);
            fill--;
            descend(1);
          end else fill = 0;
        end
      end
      CMD_DECREASE: begin
        pos = where_is[v];
        if (pos == 0 || pos > fill || heap_val[pos] != v) r.status = ST_ABSENT;
        else if (heap_key[pos] < k) r.status = ST_LARGER;
        else begin
          heap_key[pos] = k;
          climb(pos);
        end
      end
      default: ;
    endcase
    if (fill > 0) begin
      r.min_valid = 1'b1;
      r.min_key = heap_key[1];
      r.min_value = heap_val[1];
    end
    r.entry_count = fill[CNT_W-1:0];
    return r;
  endfunction

  initial begin
    fail_count = 0;
    results_seen = 0;
    pending = 0;
    fill = 0;
    cap_limit = 1024;
    for (int i = 0; i < VIDS; i++) where_is[i] = 0;
  end

  always @(posedge clk) begin
    heap_result_t e;
    if (rst_n) begin
      if (cfg_write) cap_limit = cfg_capacity;
      if (in_valid && !in_stall)
        expected_q.push_back(apply_command(in_command, in_new_key, in_item_value));
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          $error("result with nothing expected");
          fail_count++;
        end else begin
          e = expected_q.pop_front();
          if (out_status !== e.status) begin
            $error("status exp %0d got %0d", e.status, out_status); fail_count++;
          end
          if (out_key !== e.key) begin
            $error("out_key exp %0d got %0d", e.key, out_key); fail_count++;
          end
          if (out_value !== e.value) begin
            $error("out_value exp %0d got %0d", e.value, out_value); fail_count++;
          end
          if (out_min_valid !== e.min_valid) begin
            $error("min_valid exp %0d got %0d", e.min_valid, out_min_valid); fail_count++;
          end
          if (out_min_key !== e.min_key) begin
            $error("min_key exp %0d got %0d", e.min_key, out_min_key); fail_count++;
          end
          if (out_min_value !== e.min_value) begin
            $error("min_value exp %0d got %0d", e.min_value, out_min_value); fail_count++;
          end
          if (out_entry_count !== e.entry_count) begin
            $error("entry_count exp %0d got %0d", e.entry_count, out_entry_count);
            fail_count++;
          end
        end
      end
    end
    pending = expected_q.size();
  end

endmodule

// ===== verif/indexed_min_heap_test.sv =====
`timescale 1ns / 1ps
module indexed_min_heap_test;
  import imh_pkg::*;

  logic clk, rst_n;
  logic cfg_write;
  logic [CNT_W-1:0] cfg_capacity;
  logic in_valid, in_stall;
  logic [1:0] in_command;
  logic signed [31:0] in_new_key;
  logic [VAL_W-1:0] in_item_value;
  logic out_valid, out_stall;
  logic [STAT_W-1:0] out_status;
  logic signed [31:0] out_key, out_min_key;
  logic [VAL_W-1:0] out_value, out_min_value;
  logic out_min_valid;
  logic [CNT_W-1:0] out_entry_count;
  int fail_count, pending, results_seen;

  // Idle bursts on either side are switched off for the closing stretch
  bit idling_on;
  int items_sent;

  indexed_min_heap uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_write(cfg_write), .cfg_capacity(cfg_capacity),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_command(in_command), .in_new_key(in_new_key), .in_item_value(in_item_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_key(out_key), .out_value(out_value),
    .out_min_valid(out_min_valid), .out_min_key(out_min_key),
    .out_min_value(out_min_value), .out_entry_count(out_entry_count)
  );

  indexed_min_heap_checker chk (
    .clk(clk), .rst_n(rst_n),
    .cfg_write(cfg_write), .cfg_capacity(cfg_capacity),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_command(in_command), .in_new_key(in_new_key), .in_item_value(in_item_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_key(out_key), .out_value(out_value),
    .out_min_valid(out_min_valid), .out_min_key(out_min_key),
    .out_min_value(out_min_value), .out_entry_count(out_entry_count),
    .fail_count(fail_count), .pending(pending), .results_seen(results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

  // Receiver: stall in random bursts while idling is enabled
  initial begin
    int n;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (idling_on && $urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 15);
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Offer one item at the falling edge and hold it until accepted; valid
  // drops at the start of an idle gap or when draining
  task automatic send_item(logic [1:0] c, logic signed [31:0] k, logic [VAL_W-1:0] v);
    int n;
    if (idling_on && $urandom_range(0, 7) == 0) begin
      n = $urandom_range(1, 15);
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_command <= c;
    in_new_key <= k;
    in_item_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  // Drain all results, then idle for trailing work
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  task automatic set_capacity(logic [CNT_W-1:0] c);
    wait_drained();
    cfg_capacity <= c;
    cfg_write <= 1'b1;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic logic signed [31:0] rand_key();
    case ($urandom_range(0, 5))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return $signed($urandom_range(0, 15)) - 8;
      default: return $urandom;
    endcase
  endfunction

  // Mostly inserts and extracts over a small id pool, so decreases hit live ids
  task automatic random_phase(int count, int pool);
    int r;
    logic [1:0] c;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 45) c = CMD_INSERT;
      else if (r < 75) c = CMD_EXTRACT;
      else if (r < 97) c = CMD_DECREASE;
      else c = CMD_NOP;
      send_item(c, rand_key(),
                VAL_W'(($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, pool)));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_write = 1'b0;
    cfg_capacity = '0;
    in_valid = 1'b0;
    in_command = CMD_INSERT;
    in_new_key = '0;
    in_item_value = '0;
    idling_on = 1'b1;
    items_sent = 0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty extract, absent decrease, extremes, equal and larger keys
    send_item(CMD_EXTRACT, 0, 0);
    send_item(CMD_DECREASE, 0, 10'd5);
    send_item(CMD_NOP, 32'sh7FFF_FFFF, 10'h3FF);
    send_item(CMD_INSERT, 32'sh7FFF_FFFF, 10'h3FF);
    send_item(CMD_INSERT, 32'sh8000_0000, 10'd0);
    send_item(CMD_INSERT, 100, 10'd5);
    send_item(CMD_INSERT, 100, 10'd5);
    send_item(CMD_DECREASE, 100, 10'd5);
    send_item(CMD_DECREASE, 101, 10'd5);
    send_item(CMD_DECREASE, 32'sh8000_0000, 10'h3FF);
    send_item(CMD_EXTRACT, 0, 0);
    send_item(CMD_DECREASE, 0, 10'h3FF);
    send_item(CMD_EXTRACT, 0, 0);
    send_item(CMD_EXTRACT, 0, 0);
    send_item(CMD_EXTRACT, 0, 0);
    send_item(CMD_EXTRACT, 0, 0);

    // Capacity zero refuses every insert; then two fills up, then a shrink
    set_capacity(0);
    send_item(CMD_INSERT, 1, 10'd1);
    set_capacity(2);
    send_item(CMD_INSERT, 3, 10'd1);
    send_item(CMD_INSERT, 2, 10'd2);
    send_item(CMD_INSERT, 1, 10'd3);
    set_capacity(1);
    send_item(CMD_INSERT, 1, 10'd3);
    send_item(CMD_EXTRACT, 0, 0);
    send_item(CMD_EXTRACT, 0, 0);

    set_capacity(8);
    random_phase(300, 15);
    set_capacity(11'h7FF);
    random_phase(500, 63);
    set_capacity(1024);
    // Fill deep, then drain, to exercise long sift paths
    for (int i = 0; i < 200; i++) send_item(CMD_INSERT, rand_key(), VAL_W'($urandom));
    random_phase(300, 1023);
    for (int i = 0; i < 150; i++) send_item(CMD_EXTRACT, 0, 0);
    set_capacity(30);
    random_phase(300, 40);
    idling_on = 1'b0;
    random_phase(150, 40);

    wait_drained();
    $display("Sent %0d items and checked %0d results across capacities 0 to 2047.",
             items_sent, results_seen);
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
